// ----- design/edc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edc_pkg
// Shared widths, constants and beat types of the elastic disk collision block.
// ----------------------------------------------------------------------------
package edc_pkg;

   localparam int THR_W = 16;
   localparam logic [THR_W-1:0] THR_RESET = 16'd7;

   // Fraction bits of the unit normal and the mass factors
   localparam int NSHIFT = 28;

   // Squared distance and its root
   localparam int DSQ_W = 64;

   // Shared divider shape: dividend up to mass << 29, divisor up to the mass sum
   localparam int DVD_W = 61;
   localparam int DVS_W = 33;
   localparam int QUO_W = 30;

   typedef struct packed {
      logic [31:0] x1;
      logic [31:0] y1;
      logic [31:0] vx1;
      logic [31:0] vy1;
      logic [31:0] x2;
      logic [31:0] y2;
      logic [31:0] vx2;
      logic [31:0] vy2;
      logic [31:0] m1;
      logic [31:0] m2;
      logic [31:0] mag_dx;
      logic [31:0] mag_dy;
      logic        neg_dx;
      logic        neg_dy;
      logic [32:0] ux;
      logic [32:0] uy;
      logic [31:0] rs;
      logic [31:0] span;
      logic        coin;
      logic        ovl;
   } side_type;

   typedef struct packed {
      logic [31:0] new_first_x;
      logic [31:0] new_first_y;
      logic [31:0] new_first_vx;
      logic [31:0] new_first_vy;
      logic [31:0] new_second_x;
      logic [31:0] new_second_y;
      logic [31:0] new_second_vx;
      logic [31:0] new_second_vy;
      logic        collided;
      logic        coincident;
   } res_type;

endpackage

// ----- design/edc_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edc_delay
// Shift line that carries a beat and its valid bit alongside a pipelined unit.
// ----------------------------------------------------------------------------
module edc_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   output logic [W-1:0] out_data
);

   logic         valid_ff [DEPTH];
   logic [W-1:0] data_ff  [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) data_ff[i] <= data_ff[i-1];
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

// ----- design/edc_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edc_isqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module edc_isqrt #(
   parameter int DIN_W = 64
) (
   input  logic               clock,
   input  logic               adv,
   input  logic [DIN_W-1:0]   din,
   output logic [DIN_W/2-1:0] root
);

   localparam int STAGES = DIN_W / 2;

   logic [DIN_W-1:0] rem_ff  [STAGES-1];
   logic [DIN_W-1:0] root_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic [DIN_W-1:0] BIT = DIN_W'(1) << (DIN_W - 2 - 2 * i);
      logic [DIN_W-1:0] rem_prev;
      logic [DIN_W-1:0] root_prev;
      logic [DIN_W-1:0] rem_in;
      logic [DIN_W-1:0] root_in;
      logic [DIN_W:0]   trial;

      if (i == 0) begin : g_first
         assign rem_prev  = din;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
      end

      always_comb begin
         trial = {1'b0, root_prev} + {1'b0, BIT};
         if ({1'b0, rem_prev} >= trial) begin
            rem_in  = rem_prev - trial[DIN_W-1:0];
            root_in = (root_prev >> 1) + BIT;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) root_ff[i] <= root_in;
      end

      // the last stage needs only the root
      if (i < STAGES - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) rem_ff[i] <= rem_in;
         end
      end
   end

   assign root = root_ff[STAGES-1][DIN_W/2-1:0];

endmodule

// ----- design/edc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edc_div
// Pipelined restoring divider, one quotient bit per stage, truncating.
// The quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module edc_div #(
   parameter int DVD_W = 61,
   parameter int DVS_W = 33,
   parameter int QUO_W = 30
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient
);

   localparam int CW = DVS_W + QUO_W;

   logic [CW-1:0]    rem_ff [QUO_W-1];
   logic [DVS_W-1:0] dvs_ff [QUO_W-1];
   logic [QUO_W-1:0] q_ff   [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int K = QUO_W - 1 - i;
      logic [CW-1:0]    rem_prev;
      logic [DVS_W-1:0] dvs_prev;
      logic [QUO_W-1:0] q_prev;
      logic [CW-1:0]    trial;
      logic [CW-1:0]    rem_in;
      logic [QUO_W-1:0] q_in;

      if (i == 0) begin : g_first
         assign rem_prev = CW'(dividend);
         assign dvs_prev = divisor;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign dvs_prev = dvs_ff[i-1];
         assign q_prev   = q_ff[i-1];
      end

      always_comb begin
         trial = CW'(dvs_prev) << K;
         q_in  = q_prev;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            q_in[K] = 1'b1;
         end else begin
            rem_in  = rem_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) q_ff[i] <= q_in;
      end

      if (i < QUO_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[i] <= rem_in;
               dvs_ff[i] <= dvs_prev;
            end
         end
      end
   end

   assign quotient = q_ff[QUO_W-1];

endmodule

// ----- design/edc_skid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edc_skid
// Two-entry output queue that parts the pipeline from the result channel.
// ----------------------------------------------------------------------------
module edc_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  edc_pkg::res_type push_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_ready,
   output edc_pkg::res_type out_data
);
   import edc_pkg::*;

   res_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (!push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- design/elastic_disk_collision.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_disk_collision
// Elastic collision of two disks in signed Q16.16, one pair per beat.
// ----------------------------------------------------------------------------
// A pair is accepted every cycle while the output queue has room, and its
// result passes through three front stages (offsets, squares, overlap
// test), a 32-stage square root of the squared distance, a 30-stage
// divider bank for the unit normal and the mass factors, five stages of
// impulse and separation arithmetic, and a register into the output queue.
// A two-beat queue at the result side keeps the pipeline moving while a
// result waits; req_ready drops only when both queue entries hold results
// not yet taken.
module elastic_disk_collision (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_first_x,
   input  logic signed [31:0]        req_first_y,
   input  logic signed [31:0]        req_first_vx,
   input  logic signed [31:0]        req_first_vy,
   input  logic [31:0]               req_first_mass,
   input  logic [30:0]               req_first_radius,
   input  logic signed [31:0]        req_second_x,
   input  logic signed [31:0]        req_second_y,
   input  logic signed [31:0]        req_second_vx,
   input  logic signed [31:0]        req_second_vy,
   input  logic [31:0]               req_second_mass,
   input  logic [30:0]               req_second_radius,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_new_first_x,
   output logic signed [31:0]        rsp_new_first_y,
   output logic signed [31:0]        rsp_new_first_vx,
   output logic signed [31:0]        rsp_new_first_vy,
   output logic signed [31:0]        rsp_new_second_x,
   output logic signed [31:0]        rsp_new_second_y,
   output logic signed [31:0]        rsp_new_second_vx,
   output logic signed [31:0]        rsp_new_second_vy,
   output logic                      rsp_collided,
   output logic                      rsp_coincident,
   input  logic                      csr_we,
   input  logic [edc_pkg::THR_W-1:0] csr_wdata
);
   import edc_pkg::*;

   localparam int SIDE_W = $bits(side_type);

   function automatic logic [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sh0000_7fff_ffff) return 32'h7fff_ffff;
      if (v < 48'shffff_8000_0000) return 32'h8000_0000;
      return v[31:0];
   endfunction

   logic [THR_W-1:0] thr_ff;
   logic             adv;
   logic             fifo_full;

   // front stage signals
   logic [32:0] dx_c, dy_c, ux_c, uy_c;
   logic [32:0] ndx_c, ndy_c;
   side_type    p0_side_in;

   logic        p0_valid_ff, p1_valid_ff, p2_valid_ff;
   side_type    p0_side_ff, p1_side_ff, p2_side_ff;
   logic [63:0] p1_sx_ff, p1_sy_ff, p1_rs2_ff;
   logic [64:0] dsq_c;
   side_type    p2_side_in;
   logic [63:0] p2_dsq_ff;

   logic [31:0] span;
   logic        sb1_valid, sb2_valid;
   side_type    sb1_side, div_side, s2;

   logic [QUO_W-1:0] q_nx, q_ny, q_f1, q_f2;
   logic [DVS_W-1:0] msum_c;

   // impulse stages
   logic signed [30:0] nx_c, ny_c, f1_c, f2_c;
   logic signed [33:0] p_c;
   logic signed [63:0] pux_in, puy_in;
   logic signed [64:0] pox_in, poy_in;

   logic               a_valid_ff;
   side_type           a_side_ff;
   logic signed [30:0] a_nx_ff, a_ny_ff, a_f1_ff, a_f2_ff;
   logic signed [63:0] a_pux_ff, a_puy_ff;
   logic signed [64:0] a_pox_ff, a_poy_ff;

   logic signed [64:0] vsum_c;
   logic               b_valid_ff;
   side_type           b_side_ff;
   logic signed [30:0] b_nx_ff, b_ny_ff, b_f1_ff, b_f2_ff;
   logic signed [36:0] b_vn_ff;
   logic signed [35:0] b_offx_ff, b_offy_ff;

   logic               c_valid_ff;
   side_type           c_side_ff;
   logic signed [30:0] c_nx_ff, c_ny_ff;
   logic signed [67:0] c_w1p_ff, c_w2p_ff;
   logic signed [35:0] c_offx_ff, c_offy_ff;
   logic signed [67:0] w1p_in, w2p_in;

   logic signed [39:0] w1_c, w2_c;
   logic signed [70:0] d1x_in, d1y_in, d2x_in, d2y_in;
   logic               e_valid_ff;
   side_type           e_side_ff;
   logic signed [70:0] e_d1x_ff, e_d1y_ff, e_d2x_ff, e_d2y_ff;
   logic signed [35:0] e_offx_ff, e_offy_ff;

   logic signed [47:0] nx1_c, ny1_c, nvx1_c, nvy1_c, nx2_c, ny2_c, nvx2_c, nvy2_c;
   res_type            f_res_in;
   logic               f_valid_ff;
   res_type            f_res_ff;
   res_type            out_res;
   logic               push;

   // ---------------------------------------------------------------- control
   assign adv       = !fifo_full;
   assign req_ready = adv;
   assign push      = adv && f_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         e_valid_ff  <= 1'b0;
         f_valid_ff  <= 1'b0;
      end else if (adv) begin
         p0_valid_ff <= req_valid;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
         a_valid_ff  <= sb2_valid;
         b_valid_ff  <= a_valid_ff;
         c_valid_ff  <= b_valid_ff;
         e_valid_ff  <= c_valid_ff;
         f_valid_ff  <= e_valid_ff;
      end
   end

   // ---------------------------------------------------- offsets, coincidence
   assign dx_c  = {req_second_x[31], req_second_x} - {req_first_x[31], req_first_x};
   assign dy_c  = {req_second_y[31], req_second_y} - {req_first_y[31], req_first_y};
   assign ux_c  = {req_second_vx[31], req_second_vx} - {req_first_vx[31], req_first_vx};
   assign uy_c  = {req_second_vy[31], req_second_vy} - {req_first_vy[31], req_first_vy};
   assign ndx_c = -dx_c;
   assign ndy_c = -dy_c;

   always_comb begin
      p0_side_in.x1     = req_first_x;
      p0_side_in.y1     = req_first_y;
      p0_side_in.vx1    = req_first_vx;
      p0_side_in.vy1    = req_first_vy;
      p0_side_in.x2     = req_second_x;
      p0_side_in.y2     = req_second_y;
      p0_side_in.vx2    = req_second_vx;
      p0_side_in.vy2    = req_second_vy;
      p0_side_in.m1     = req_first_mass;
      p0_side_in.m2     = req_second_mass;
      p0_side_in.neg_dx = dx_c[32];
      p0_side_in.neg_dy = dy_c[32];
      p0_side_in.mag_dx = dx_c[32] ? ndx_c[31:0] : dx_c[31:0];
      p0_side_in.mag_dy = dy_c[32] ? ndy_c[31:0] : dy_c[31:0];
      p0_side_in.ux     = ux_c;
      p0_side_in.uy     = uy_c;
      p0_side_in.rs     = {1'b0, req_first_radius} + {1'b0, req_second_radius};
      p0_side_in.span   = '0;
      p0_side_in.coin   = (p0_side_in.mag_dx < {16'b0, thr_ff} &&
                           p0_side_in.mag_dy < {16'b0, thr_ff}) ||
                          (dx_c == 33'd0 && dy_c == 33'd0);
      p0_side_in.ovl    = 1'b0;
   end

   assign dsq_c = {1'b0, p1_sx_ff} + {1'b0, p1_sy_ff};

   always_comb begin
      p2_side_in     = p1_side_ff;
      // a carry out of the squared sum counts as no overlap
      p2_side_in.ovl = !dsq_c[64] && (dsq_c[63:0] < p1_rs2_ff) && !p1_side_ff.coin;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_side_ff <= p0_side_in;
         p1_side_ff <= p0_side_ff;
         p1_sx_ff   <= p0_side_ff.mag_dx * p0_side_ff.mag_dx;
         p1_sy_ff   <= p0_side_ff.mag_dy * p0_side_ff.mag_dy;
         p1_rs2_ff  <= p0_side_ff.rs * p0_side_ff.rs;
         p2_side_ff <= p2_side_in;
         p2_dsq_ff  <= dsq_c[63:0];
      end
   end

   // ------------------------------------------------------------ square root
   edc_isqrt #(.DIN_W(DSQ_W)) u_isqrt (
      .clock (clock),
      .adv   (adv),
      .din   (p2_dsq_ff),
      .root  (span)
   );

   edc_delay #(.W(SIDE_W), .DEPTH(DSQ_W / 2)) u_sb1 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (p2_valid_ff),
      .in_data   (p2_side_ff),
      .out_valid (sb1_valid),
      .out_data  (sb1_side)
   );

   // --------------------------------------------------------------- dividers
   always_comb begin
      div_side      = sb1_side;
      div_side.span = span;
   end

   assign msum_c = {1'b0, sb1_side.m1} + {1'b0, sb1_side.m2};

   edc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W), .QUO_W(QUO_W)) u_div_nx (
      .clock    (clock),
      .adv      (adv),
      .dividend (DVD_W'(sb1_side.mag_dx) << NSHIFT),
      .divisor  (DVS_W'(span)),
      .quotient (q_nx)
   );

   edc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W), .QUO_W(QUO_W)) u_div_ny (
      .clock    (clock),
      .adv      (adv),
      .dividend (DVD_W'(sb1_side.mag_dy) << NSHIFT),
      .divisor  (DVS_W'(span)),
      .quotient (q_ny)
   );

   edc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W), .QUO_W(QUO_W)) u_div_f1 (
      .clock    (clock),
      .adv      (adv),
      .dividend (DVD_W'(sb1_side.m2) << (NSHIFT + 1)),
      .divisor  (msum_c),
      .quotient (q_f1)
   );

   edc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W), .QUO_W(QUO_W)) u_div_f2 (
      .clock    (clock),
      .adv      (adv),
      .dividend (DVD_W'(sb1_side.m1) << (NSHIFT + 1)),
      .divisor  (msum_c),
      .quotient (q_f2)
   );

   edc_delay #(.W(SIDE_W), .DEPTH(QUO_W)) u_sb2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sb1_valid),
      .in_data   (div_side),
      .out_valid (sb2_valid),
      .out_data  (s2)
   );

   // ------------------------------------------------------ normal, products
   always_comb begin
      nx_c = s2.neg_dx ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
      ny_c = s2.neg_dy ? -$signed({1'b0, q_ny}) : $signed({1'b0, q_ny});
      // both masses zero: each factor is one
      if (s2.m1 == 32'd0 && s2.m2 == 32'd0) begin
         f1_c = 31'sd1 <<< NSHIFT;
         f2_c = 31'sd1 <<< NSHIFT;
      end else begin
         f1_c = $signed({1'b0, q_f1});
         f2_c = $signed({1'b0, q_f2});
      end
      p_c    = $signed({2'b0, s2.rs}) - $signed({2'b0, s2.span});
      pux_in = $signed(s2.ux) * nx_c;
      puy_in = $signed(s2.uy) * ny_c;
      pox_in = p_c * nx_c;
      poy_in = p_c * ny_c;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff <= s2;
         a_nx_ff   <= nx_c;
         a_ny_ff   <= ny_c;
         a_f1_ff   <= f1_c;
         a_f2_ff   <= f2_c;
         a_pux_ff  <= pux_in;
         a_puy_ff  <= puy_in;
         a_pox_ff  <= pox_in;
         a_poy_ff  <= poy_in;
      end
   end

   // normal speed and separation offsets, floor by dropping low bits
   assign vsum_c = 65'(a_pux_ff) + 65'(a_puy_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         b_side_ff <= a_side_ff;
         b_nx_ff   <= a_nx_ff;
         b_ny_ff   <= a_ny_ff;
         b_f1_ff   <= a_f1_ff;
         b_f2_ff   <= a_f2_ff;
         b_vn_ff   <= vsum_c[64:28];
         b_offx_ff <= a_pox_ff[64:29];
         b_offy_ff <= a_poy_ff[64:29];
      end
   end

   assign w1p_in = b_f1_ff * b_vn_ff;
   assign w2p_in = b_f2_ff * b_vn_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         c_side_ff <= b_side_ff;
         c_nx_ff   <= b_nx_ff;
         c_ny_ff   <= b_ny_ff;
         c_w1p_ff  <= w1p_in;
         c_w2p_ff  <= w2p_in;
         c_offx_ff <= b_offx_ff;
         c_offy_ff <= b_offy_ff;
      end
   end

   always_comb begin
      w1_c   = c_w1p_ff[67:28];
      w2_c   = c_w2p_ff[67:28];
      d1x_in = w1_c * c_nx_ff;
      d1y_in = w1_c * c_ny_ff;
      d2x_in = w2_c * c_nx_ff;
      d2y_in = w2_c * c_ny_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff <= c_side_ff;
         e_d1x_ff  <= d1x_in;
         e_d1y_ff  <= d1y_in;
         e_d2x_ff  <= d2x_in;
         e_d2y_ff  <= d2y_in;
         e_offx_ff <= c_offx_ff;
         e_offy_ff <= c_offy_ff;
      end
   end

   // -------------------------------------------------- apply, select, clamp
   always_comb begin
      nvx1_c = 48'($signed(e_side_ff.vx1)) + 48'($signed(e_d1x_ff[70:28]));
      nvy1_c = 48'($signed(e_side_ff.vy1)) + 48'($signed(e_d1y_ff[70:28]));
      nvx2_c = 48'($signed(e_side_ff.vx2)) - 48'($signed(e_d2x_ff[70:28]));
      nvy2_c = 48'($signed(e_side_ff.vy2)) - 48'($signed(e_d2y_ff[70:28]));
      nx1_c  = 48'($signed(e_side_ff.x1)) - 48'(e_offx_ff);
      ny1_c  = 48'($signed(e_side_ff.y1)) - 48'(e_offy_ff);
      nx2_c  = 48'($signed(e_side_ff.x2)) + 48'(e_offx_ff);
      ny2_c  = 48'($signed(e_side_ff.y2)) + 48'(e_offy_ff);

      if (e_side_ff.ovl) begin
         f_res_in.new_first_x   = sat32(nx1_c);
         f_res_in.new_first_y   = sat32(ny1_c);
         f_res_in.new_first_vx  = sat32(nvx1_c);
         f_res_in.new_first_vy  = sat32(nvy1_c);
         f_res_in.new_second_x  = sat32(nx2_c);
         f_res_in.new_second_y  = sat32(ny2_c);
         f_res_in.new_second_vx = sat32(nvx2_c);
         f_res_in.new_second_vy = sat32(nvy2_c);
      end else begin
         // pass the pair through untouched
         f_res_in.new_first_x   = e_side_ff.x1;
         f_res_in.new_first_y   = e_side_ff.y1;
         f_res_in.new_first_vx  = e_side_ff.vx1;
         f_res_in.new_first_vy  = e_side_ff.vy1;
         f_res_in.new_second_x  = e_side_ff.x2;
         f_res_in.new_second_y  = e_side_ff.y2;
         f_res_in.new_second_vx = e_side_ff.vx2;
         f_res_in.new_second_vy = e_side_ff.vy2;
      end
      f_res_in.collided   = e_side_ff.ovl || e_side_ff.coin;
      f_res_in.coincident = e_side_ff.coin;
   end

   always_ff @(posedge clock) begin
      if (adv) f_res_ff <= f_res_in;
   end

   // ----------------------------------------------------------- output queue
   edc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (f_res_ff),
      .full      (fifo_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_res)
   );

   assign rsp_new_first_x   = out_res.new_first_x;
   assign rsp_new_first_y   = out_res.new_first_y;
   assign rsp_new_first_vx  = out_res.new_first_vx;
   assign rsp_new_first_vy  = out_res.new_first_vy;
   assign rsp_new_second_x  = out_res.new_second_x;
   assign rsp_new_second_y  = out_res.new_second_y;
   assign rsp_new_second_vx = out_res.new_second_vx;
   assign rsp_new_second_vy = out_res.new_second_vy;
   assign rsp_collided      = out_res.collided;
   assign rsp_coincident    = out_res.coincident;

   // ------------------------------------------------------------- assertions
   a_coin_collided: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coincident |-> rsp_collided)
      else $error("coincident beat without collided flag");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   a_ovl_not_coin: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff && e_side_ff.ovl |-> !e_side_ff.coin)
      else $error("overlap and coincidence both set");

   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      adv && e_valid_ff && !e_side_ff.ovl |=>
         f_res_ff.new_first_x == $past(e_side_ff.x1) &&
         f_res_ff.new_second_vy == $past(e_side_ff.vy2))
      else $error("untouched pair altered");

endmodule
